@@ sv/peer_table_with_ttl_aging_assert.svh @@
// Assertion macros used by the checker file.
`ifndef PEER_TABLE_WITH_TTL_AGING_ASSERT_SVH
`define PEER_TABLE_WITH_TTL_AGING_ASSERT_SVH

// Checked outside reset.
`define PTT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PTT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/ptt_pkg.sv @@
`default_nettype none
package ptt_pkg;

	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_FIND = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;

	localparam logic REG_TTL_RELOAD = 1'b0;
	localparam logic REG_SCAN_ALL   = 1'b1;

	localparam logic [7:0] TTL_RELOAD_RST = 8'd10;

	localparam int unsigned IN_W   = 64;
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		CMD_ADD,
		CMD_FIND,
		CMD_TICK,
		CMD_NOP
	} cmd_kind_t;

	typedef enum logic [1:0] {
		ST_REFRESH,
		ST_INSERT,
		ST_FULL,
		ST_REJECT
	} add_status_t;

	typedef enum logic [1:0] {
		E_IDLE,
		E_SCAN,
		E_LAST,
		E_FIN
	} eng_state_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [47:0]        addr;
		logic signed [7:0]  strength;
		logic               present;
		logic               badge;
	} cmd_t;

	typedef struct packed {
		logic [47:0]        addr;
		logic signed [7:0]  strength;
		logic [7:0]         ttl;
	} entry_t;

	typedef struct packed {
		logic               entry_badge;
		logic [7:0]         entry_ttl;
		logic signed [7:0]  entry_strength;
		logic [3:0]         entry_index;
		logic               hit;
		add_status_t        add_status;
	} res_t;

	localparam int unsigned OUT_W = $bits(res_t);

endpackage
`default_nettype wire

@@ sv/ptt_front.sv @@
`default_nettype none
module ptt_front import ptt_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [IN_W-1:0] s_tdata,
	input  wire logic [1:0]      s_tuser,
	output logic                 push,
	output cmd_t                 push_cmd,
	input  wire logic            q_full
);

	logic      v_s1;
	cmd_t      cmd_s1;
	cmd_kind_t kind;
	logic      take;

	always_comb begin
		unique case (s_tuser)
			OP_ADD:  kind = CMD_ADD;
			OP_FIND: kind = CMD_FIND;
			OP_TICK: kind = CMD_TICK;
			default: kind = CMD_NOP;
		endcase
	end

	assign push     = v_s1 && !q_full;
	assign s_tready = !v_s1 || !q_full;
	assign take     = s_tvalid && s_tready;
	assign push_cmd = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1.kind     <= kind;
			cmd_s1.addr     <= s_tdata[47:0];
			cmd_s1.strength <= s_tdata[55:48];
			cmd_s1.present  <= s_tdata[56];
			cmd_s1.badge    <= s_tdata[57];
		end
	end

endmodule
`default_nettype wire

@@ sv/ptt_queue.sv @@
`default_nettype none
module ptt_queue import ptt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t din,
	output logic      full,
	input  wire logic pop,
	output cmd_t      dout,
	output logic      valid
);

	cmd_t           mem_q [QDEPTH];
	logic [QAW-1:0] wptr_q, rptr_q;
	logic [QAW:0]   cnt_q;

	assign full  = cnt_q == (QAW+1)'(QDEPTH);
	assign valid = cnt_q != '0;
	assign dout  = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= din;
		end
	end

endmodule
`default_nettype wire

@@ sv/ptt_engine.sv @@
`default_nettype none
module ptt_engine import ptt_pkg::*; #(
	parameter int unsigned ENTRIES = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [7:0]       ttl_reload,
	input  wire logic             scan_all,
	input  wire logic             q_valid,
	input  wire cmd_t             q_cmd,
	output logic                  q_pop,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata
);

	localparam int unsigned IW = $clog2(ENTRIES);

	eng_state_t       state_q, state_d;
	cmd_t             cmd_q;
	logic [IW-1:0]    idx_q, ridx_q, midx_q, fidx_q;
	logic             rvalid_q, match_q, free_q;
	entry_t           rdata_q, mdata_q;
	logic [ENTRIES-1:0] used_q, badge_q;
	entry_t           mem [ENTRIES];

	logic             rd_en, out_free, fin;
	logic             hit_now, free_now, age, expire;
	logic [IW-1:0]    slot;
	logic             found, new_badge, admit, add_go;
	logic             we;
	logic [IW-1:0]    waddr;
	entry_t           wdata;
	res_t             res;
	logic             m_tvalid_q;
	res_t             res_q;

	assign q_pop    = (state_q == E_IDLE) && q_valid;
	assign rd_en    = state_q == E_SCAN;
	assign out_free = !m_tvalid_q || m_tready;
	assign fin      = (state_q == E_FIN) && out_free;

	assign hit_now  = rvalid_q && used_q[ridx_q] && (rdata_q.addr == cmd_q.addr);
	assign free_now = rvalid_q && !used_q[ridx_q];
	assign age      = rvalid_q && (cmd_q.kind == CMD_TICK) && used_q[ridx_q];
	assign expire   = age && (rdata_q.ttl <= 8'd1);

	assign slot      = match_q ? midx_q : fidx_q;
	assign found     = match_q || free_q;
	assign new_badge = cmd_q.present ? cmd_q.badge : badge_q[slot];
	assign admit     = scan_all || new_badge;
	assign add_go    = fin && (cmd_q.kind == CMD_ADD) && found;

	always_comb begin
		we    = (age && !expire) || (add_go && admit);
		waddr = add_go ? slot : ridx_q;
		if (add_go) begin
			wdata.addr     = cmd_q.addr;
			wdata.strength = cmd_q.strength;
			wdata.ttl      = ttl_reload;
		end else begin
			wdata.addr     = rdata_q.addr;
			wdata.strength = rdata_q.strength;
			wdata.ttl      = rdata_q.ttl - 8'd1;
		end
	end

	always_comb begin
		res = '0;
		case (cmd_q.kind)
			CMD_ADD: begin
				if (!found) begin
					res.add_status = ST_FULL;
				end else begin
					res.entry_index = 4'(slot);
					if (!admit) begin
						res.add_status = ST_REJECT;
					end else if (match_q) begin
						res.add_status = ST_REFRESH;
					end else begin
						res.add_status = ST_INSERT;
					end
				end
			end
			CMD_FIND: begin
				if (match_q) begin
					res.hit            = 1'b1;
					res.entry_index    = 4'(midx_q);
					res.entry_strength = mdata_q.strength;
					res.entry_ttl      = mdata_q.ttl;
					res.entry_badge    = badge_q[midx_q];
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			E_IDLE: begin
				if (q_valid) begin
					state_d = (q_cmd.kind == CMD_NOP) ? E_FIN : E_SCAN;
				end
			end
			E_SCAN: begin
				if (idx_q == IW'(ENTRIES - 1)) begin
					state_d = E_LAST;
				end
			end
			E_LAST: begin
				state_d = E_FIN;
			end
			E_FIN: begin
				if (out_free) begin
					state_d = E_IDLE;
				end
			end
			default: begin
				state_d = E_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			rvalid_q   <= 1'b0;
			match_q    <= 1'b0;
			free_q     <= 1'b0;
			used_q     <= '0;
			badge_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			rvalid_q <= rd_en;
			if (q_pop) begin
				idx_q   <= '0;
				match_q <= 1'b0;
				free_q  <= 1'b0;
			end else begin
				if (rd_en) begin
					idx_q <= idx_q + 1'b1;
				end
				if (hit_now && !match_q) begin
					match_q <= 1'b1;
				end
				if (free_now && !free_q) begin
					free_q <= 1'b1;
				end
			end
			if (expire) begin
				used_q[ridx_q]  <= 1'b0;
				badge_q[ridx_q] <= 1'b0;
			end
			if (add_go) begin
				if (cmd_q.present) begin
					badge_q[slot] <= cmd_q.badge;
				end
				if (admit) begin
					used_q[slot] <= 1'b1;
				end
			end
			if (fin) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		ridx_q <= idx_q;
		if (hit_now && !match_q) begin
			midx_q  <= ridx_q;
			mdata_q <= rdata_q;
		end
		if (free_now && !free_q) begin
			fidx_q <= ridx_q;
		end
		if (fin) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = res_q;

endmodule
`default_nettype wire

@@ sv/peer_table_with_ttl_aging.sv @@
// Peer table of ENTRIES slots keyed by 48-bit address. Each transfer on the
// input stream is an add, find or tick (tuser) and yields exactly one result
// transfer. Items are decoded into a two-deep command queue, and a back-end
// engine then sweeps the entry memory one slot per cycle through its single
// read port: an add, find or tick runs through pop, a read of each slot,
// the last compare and the result; an unknown operation goes from pop to
// the result, which may then wait on m_tready. Slot valid and badge bits
// are flip-flops cleared by reset, so the table is usable right after
// reset. Write ttl_reload and scan_all only while the block is idle.
`default_nettype none
module peer_table_with_ttl_aging import ptt_pkg::*; #(
	parameter int unsigned ENTRIES = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	// peer_address[47:0], signal_strength[55:48], vendor_data_present[56],
	// vendor_is_badge[57], zero[63:58]
	input  wire logic [IN_W-1:0]  s_tdata,
	// operation[1:0]
	input  wire logic [1:0]       s_tuser,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	// add_status[1:0], hit[2], entry_index[6:3], entry_strength[14:7],
	// entry_ttl[22:15], entry_badge[23]
	output logic [OUT_W-1:0]      m_tdata,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic             cfg_index,
	input  wire logic [7:0]       cfg_data
);

	logic [7:0] ttl_reload_q;
	logic       scan_all_q;
	logic       push, q_full, q_valid, q_pop;
	cmd_t       push_cmd, q_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_reload_q <= TTL_RELOAD_RST;
			scan_all_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TTL_RELOAD: ttl_reload_q <= cfg_data;
				REG_SCAN_ALL:   scan_all_q   <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	ptt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.push     (push),
		.push_cmd (push_cmd),
		.q_full   (q_full)
	);

	ptt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_cmd),
		.valid  (q_valid)
	);

	ptt_engine #(
		.ENTRIES (ENTRIES)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.ttl_reload (ttl_reload_q),
		.scan_all   (scan_all_q),
		.q_valid    (q_valid),
		.q_cmd      (q_cmd),
		.q_pop      (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule
`default_nettype wire

@@ sv/ptt_checker.sv @@
`default_nettype none
`include "peer_table_with_ttl_aging_assert.svh"
module ptt_checker import ptt_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata
);

	`PTT_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
	`PTT_ASSERT(a_out_stable, m_tvalid && !m_tready |=> $stable(m_tdata), "stalled result changed")
	`PTT_ASSERT(a_hit_status, m_tvalid && m_tdata[2] |-> m_tdata[1:0] == ST_REFRESH, "find hit with add status")
	`PTT_ASSERT(a_full_idx, m_tvalid && m_tdata[1:0] == ST_FULL |-> m_tdata[6:3] == 4'd0, "full add with index")
	`PTT_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !m_tvalid, "result valid in reset")

endmodule

bind peer_table_with_ttl_aging ptt_checker u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

@@ sim/peer_table_with_ttl_aging_tb.sv @@
`timescale 1ns / 1ps

module peer_table_with_ttl_aging_tb;
	import ptt_pkg::*;

	localparam int ENTRIES   = 16;
	localparam int POOL_SIZE = 24;
	localparam int PHASES    = 5;
	localparam int PER_PHASE = 160;
	localparam logic [47:0] ADDR_TOP = '1;

	typedef struct packed {
		cmd_t cmd;
		logic fixed;
		res_t want;
	} probe_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_W-1:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [7:0] cfg_data;

	// shadow copy of the table and its registers
	bit peer_used [ENTRIES];
	logic [47:0] peer_mac [ENTRIES];
	logic signed [7:0] peer_rssi [ENTRIES];
	logic [7:0] peer_ttl [ENTRIES];
	bit peer_badge [ENTRIES];
	logic [7:0] ttl_reload_q = TTL_RELOAD_RST;
	bit scan_all_q = 1'b0;

	res_t expected_results [$];
	int mismatches = 0;
	int results_seen = 0;
	bit calm = 1'b0;

	peer_table_with_ttl_aging #(.ENTRIES(ENTRIES)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("[peer_table_with_ttl_aging] ERROR");
		$finish;
	end

	function automatic cmd_t peer_cmd(cmd_kind_t kind, logic [47:0] addr,
			logic signed [7:0] rssi, logic present, logic badge);
		cmd_t c;
		c.kind = kind;
		c.addr = addr;
		c.strength = rssi;
		c.present = present;
		c.badge = badge;
		return c;
	endfunction

	function automatic res_t peer_res(add_status_t status, logic hit, logic [3:0] idx,
			logic signed [7:0] rssi, logic [7:0] ttl, logic badge);
		res_t r;
		r.add_status = status;
		r.hit = hit;
		r.entry_index = idx;
		r.entry_strength = rssi;
		r.entry_ttl = ttl;
		r.entry_badge = badge;
		return r;
	endfunction

	function automatic int locate_peer(logic [47:0] addr);
		for (int i = 0; i < ENTRIES; i++)
			if (peer_used[i] && peer_mac[i] == addr)
				return i;
		return -1;
	endfunction

	function automatic res_t table_apply(cmd_t c);
		res_t r;
		int slot;
		r = '0;
		case (c.kind)
			CMD_ADD: begin
				r.add_status = ST_REFRESH;
				slot = locate_peer(c.addr);
				if (slot < 0) begin
					for (int i = 0; i < ENTRIES; i++)
						if (!peer_used[i] && slot < 0)
							slot = i;
					if (slot < 0) begin
						r.add_status = ST_FULL;
						return r;
					end
					r.add_status = ST_INSERT;
				end
				if (c.present)
					peer_badge[slot] = c.badge;
				r.entry_index = 4'(slot);
				if (!scan_all_q && !peer_badge[slot]) begin
					r.add_status = ST_REJECT;
				end else begin
					peer_mac[slot] = c.addr;
					peer_rssi[slot] = c.strength;
					peer_ttl[slot] = ttl_reload_q;
					peer_used[slot] = 1'b1;
				end
			end
			CMD_FIND: begin
				slot = locate_peer(c.addr);
				if (slot >= 0) begin
					r.hit = 1'b1;
					r.entry_index = 4'(slot);
					r.entry_strength = peer_rssi[slot];
					r.entry_ttl = peer_ttl[slot];
					r.entry_badge = peer_badge[slot];
				end
			end
			CMD_TICK: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (peer_used[i]) begin
						if (peer_ttl[i] <= 8'd1) begin
							peer_used[i] = 1'b0;
							peer_mac[i] = '0;
							peer_rssi[i] = '0;
							peer_ttl[i] = '0;
							peer_badge[i] = 1'b0;
						end else begin
							peer_ttl[i] = peer_ttl[i] - 8'd1;
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_cmd(input cmd_t c, input logic fixed, input res_t want);
		res_t predicted;
		while (!calm && $urandom_range(99) < 8) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= c.kind;
		s_tdata <= {6'd0, c.badge, c.present, c.strength, c.addr};
		do @(posedge clk); while (!s_tready);
		predicted = table_apply(c);
		expected_results.push_back(fixed ? want : predicted);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_TTL_RELOAD)
			ttl_reload_q = value;
		else
			scan_all_q = value[0];
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	initial begin : result_sink
		res_t got;
		res_t want;
		int hold_left;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				results_seen++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transfer %h", got);
				end else begin
					want = expected_results.pop_front();
					if (got.add_status != want.add_status || got.hit != want.hit ||
							got.entry_index != want.entry_index ||
							got.entry_strength != want.entry_strength ||
							got.entry_ttl != want.entry_ttl ||
							got.entry_badge != want.entry_badge) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: exp st=%0d hit=%0d idx=%0d rssi=%0d ttl=%0d badge=%0d, got st=%0d hit=%0d idx=%0d rssi=%0d ttl=%0d badge=%0d",
								results_seen, want.add_status, want.hit, want.entry_index,
								want.entry_strength, want.entry_ttl, want.entry_badge,
								got.add_status, got.hit, got.entry_index,
								got.entry_strength, got.entry_ttl, got.entry_badge);
					end
				end
				// long hold-off so the input side backs up
				if (results_seen == 200)
					hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= calm || ($urandom_range(99) >= 8);
			end
		end
	end

	initial begin : stimulus
		probe_t probes [$];
		logic [47:0] addr_pool [POOL_SIZE];
		int ttl_set [PHASES];
		bit scan_set [PHASES];
		cmd_t c;
		int pick;

		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_TTL_RELOAD;
		cfg_data <= '0;
		for (int i = 0; i < ENTRIES; i++) begin
			peer_used[i] = 1'b0;
			peer_mac[i] = '0;
			peer_rssi[i] = '0;
			peer_ttl[i] = '0;
			peer_badge[i] = 1'b0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: ttl 10, badges only
		probes.push_back({peer_cmd(CMD_FIND, 48'h0, 8'sd0, 1'b0, 1'b0), 1'b1, res_t'('0)});
		probes.push_back({peer_cmd(CMD_TICK, 48'h0, 8'sd0, 1'b0, 1'b0), 1'b1, res_t'('0)});
		probes.push_back({peer_cmd(CMD_NOP, ADDR_TOP, -8'sd128, 1'b1, 1'b1), 1'b1,
			res_t'('0)});
		probes.push_back({peer_cmd(CMD_ADD, ADDR_TOP, -8'sd128, 1'b1, 1'b1), 1'b1,
			peer_res(ST_INSERT, 1'b0, 4'd0, 8'sd0, 8'd0, 1'b0)});
		probes.push_back({peer_cmd(CMD_FIND, ADDR_TOP, 8'sd0, 1'b0, 1'b0), 1'b1,
			peer_res(ST_REFRESH, 1'b1, 4'd0, -8'sd128, 8'd10, 1'b1)});
		probes.push_back({peer_cmd(CMD_ADD, 48'h0, 8'sd127, 1'b1, 1'b0), 1'b1,
			peer_res(ST_REJECT, 1'b0, 4'd1, 8'sd0, 8'd0, 1'b0)});
		probes.push_back({peer_cmd(CMD_FIND, 48'h0, 8'sd0, 1'b0, 1'b0), 1'b1, res_t'('0)});
		probes.push_back({peer_cmd(CMD_ADD, 48'h0, 8'sd127, 1'b0, 1'b1), 1'b1,
			peer_res(ST_REJECT, 1'b0, 4'd1, 8'sd0, 8'd0, 1'b0)});
		// vendor data from another company clears the flag of a used slot
		probes.push_back({peer_cmd(CMD_ADD, ADDR_TOP, 8'sd5, 1'b1, 1'b0), 1'b1,
			peer_res(ST_REJECT, 1'b0, 4'd0, 8'sd0, 8'd0, 1'b0)});
		probes.push_back({peer_cmd(CMD_FIND, ADDR_TOP, 8'sd0, 1'b0, 1'b0), 1'b1,
			peer_res(ST_REFRESH, 1'b1, 4'd0, -8'sd128, 8'd10, 1'b0)});
		probes.push_back({peer_cmd(CMD_ADD, ADDR_TOP, -8'sd1, 1'b0, 1'b0), 1'b1,
			peer_res(ST_REJECT, 1'b0, 4'd0, 8'sd0, 8'd0, 1'b0)});
		probes.push_back({peer_cmd(CMD_ADD, ADDR_TOP, -8'sd1, 1'b1, 1'b1), 1'b1,
			peer_res(ST_REFRESH, 1'b0, 4'd0, 8'sd0, 8'd0, 1'b0)});
		probes.push_back({peer_cmd(CMD_TICK, ADDR_TOP, 8'sd0, 1'b1, 1'b1), 1'b1,
			res_t'('0)});
		probes.push_back({peer_cmd(CMD_FIND, ADDR_TOP, 8'sd0, 1'b0, 1'b0), 1'b0, res_t'('0)});
		probes.push_back({peer_cmd(CMD_ADD, 48'h1, 8'sd0, 1'b1, 1'b1), 1'b1,
			peer_res(ST_INSERT, 1'b0, 4'd1, 8'sd0, 8'd0, 1'b0)});
		probes.push_back({peer_cmd(CMD_ADD, 48'h8000_0000_0000, 8'sd1, 1'b0, 1'b0), 1'b1,
			peer_res(ST_REJECT, 1'b0, 4'd2, 8'sd0, 8'd0, 1'b0)});
		probes.push_back({peer_cmd(CMD_ADD, 48'h5555_5555_5555, 8'sh55, 1'b1, 1'b1),
			1'b0, res_t'('0)});
		probes.push_back({peer_cmd(CMD_FIND, 48'hAAAA_AAAA_AAAA, 8'sd0, 1'b1, 1'b1), 1'b1,
			res_t'('0)});
		probes.push_back({peer_cmd(CMD_FIND, 48'h5555_5555_5555, 8'sd0, 1'b0, 1'b0),
			1'b0, res_t'('0)});
		foreach (probes[i])
			send_cmd(probes[i].cmd, probes[i].fixed, probes[i].want);
		drain();

		addr_pool[0] = '0;
		addr_pool[1] = ADDR_TOP;
		for (int i = 2; i < POOL_SIZE; i++)
			addr_pool[i] = 48'({$urandom, $urandom});

		ttl_set = '{255, 1, 3, 0, 10};
		scan_set = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
		ttl_set[3] = $urandom_range(255, 1);
		scan_set[3] = $urandom_range(1);

		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_TTL_RELOAD, 8'(ttl_set[p]));
			write_reg(REG_SCAN_ALL, {7'd0, scan_set[p]});
			calm = (p == 2);
			for (int n = 0; n < PER_PHASE; n++) begin
				pick = $urandom_range(99);
				c.kind = pick < 45 ? CMD_ADD : pick < 80 ? CMD_FIND :
					pick < 95 ? CMD_TICK : CMD_NOP;
				c.addr = ($urandom_range(99) < 85) ? addr_pool[$urandom_range(POOL_SIZE - 1)]
					: 48'({$urandom, $urandom});
				c.strength = 8'($urandom);
				c.present = $urandom_range(99) < 70;
				c.badge = $urandom_range(99) < 75;
				send_cmd(c, 1'b0, res_t'('0));
			end
			calm = 1'b0;
			drain();
		end

		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("[peer_table_with_ttl_aging] OK");
		end else begin
			$display("[peer_table_with_ttl_aging] ERROR");
		end
		$finish;
	end

endmodule
